// ----- sv/wfc_pkg.sv -----
// shared constants, types and character helpers for the word frequency counter
package wfc_pkg;

    localparam int TABLE_ENTRIES  = 64;
    localparam int MAX_WORD_BYTES = 32;
    localparam int IDX_W          = $clog2(TABLE_ENTRIES);
    localparam int USED_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int LEN_W          = $clog2(MAX_WORD_BYTES + 1);
    localparam int BYTE_IDX_W     = $clog2(MAX_WORD_BYTES);
    localparam int CHARS_W        = MAX_WORD_BYTES * 8;
    localparam int ROW_W          = CHARS_W + LEN_W;
    localparam int TALLY_W        = 16;
    localparam int CFG_W          = 6;
    localparam int STATUS_W       = 2;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

    localparam logic [TALLY_W-1:0]  TALLY_MAX   = '1;
    localparam logic [CFG_W-1:0]    MIN_LEN_RST = CFG_W'(3);
    localparam logic [STATUS_W-1:0] ST_COUNTED  = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_FULL     = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_LONG     = STATUS_W'(2);

    // one finished word as handed from front to back
    typedef struct packed {
        logic               over;
        logic [LEN_W-1:0]   len;
        logic [CHARS_W-1:0] chars;
    } word_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

    function automatic logic is_dropped(input logic [7:0] c);
        return c inside {8'h2E, 8'h21, 8'h3F, 8'h2D, 8'h2C, 8'h28, 8'h29, 8'h27};
    endfunction

endpackage

// ----- sv/wfc_ram.sv -----
// generic ram, one write port and one registered read port
module wfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/wfc_front.sv -----
// front part: takes bytes, builds the stripped word and queues finished words
module wfc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         text_byte,
    input  logic               end_of_text,
    output logic               push,
    output wfc_pkg::word_t     push_word
);
    import wfc_pkg::*;

    logic [LEN_W-1:0]   len_reg, len_next, len_add;
    logic               over_reg, over_next, over_add;
    logic [CHARS_W-1:0] buf_reg, buf_add;
    logic [7:0]         low_c;
    logic               space_c, keep_c, finish;

    // classify and fold case
    always_comb
    begin
        space_c = is_space(text_byte);
        keep_c  = !space_c && !is_dropped(text_byte);
        low_c   = text_byte;
        if (text_byte inside {[8'h41:8'h5A]})
        begin
            low_c = text_byte + 8'h20;
        end
    end

    // word after this byte is appended
    always_comb
    begin
        len_add  = len_reg;
        over_add = over_reg;
        buf_add  = buf_reg;
        if (keep_c)
        begin
            if (len_reg < LEN_W'(MAX_WORD_BYTES))
            begin
                buf_add[len_reg[BYTE_IDX_W-1:0]*8 +: 8] = low_c;
                len_add = len_reg + LEN_W'(1);
            end
            else
            begin
                over_add = 1'b1;
            end
        end
        finish = space_c || end_of_text;
    end

    // finished word with bytes past the end cleared
    always_comb
    begin
        push_word.over = over_add;
        push_word.len  = len_add;
        for (int i = 0; i < MAX_WORD_BYTES; i++)
        begin
            push_word.chars[i*8 +: 8] = (LEN_W'(i) < len_add) ? buf_add[i*8 +: 8] : 8'h00;
        end
        push = accept && finish && (over_add || (len_add != '0));
        len_next  = len_reg;
        over_next = over_reg;
        if (accept)
        begin
            len_next  = finish ? '0 : len_add;
            over_next = finish ? 1'b0 : over_add;
        end
    end

    // word state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            over_reg <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            over_reg <= over_next;
        end
    end

    // byte buffer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_reg <= buf_add;
        end
    end

endmodule

// ----- sv/wfc_queue.sv -----
// short queue of finished words between front and back
module wfc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  wfc_pkg::word_t push_word,
    input  logic           pop,
    output wfc_pkg::word_t pop_word,
    output logic           empty,
    output logic           full
);
    import wfc_pkg::*;

    word_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_reg, rd_reg;
    logic [QPTR_W:0]     cnt_reg;

    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_word = slot_reg[rd_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_word;
        end
    end

endmodule

// ----- sv/wfc_back.sv -----
// back part: table search, tally update, insert and result register
module wfc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [wfc_pkg::CFG_W-1:0]     min_len,
    input  logic                          q_empty,
    input  wfc_pkg::word_t                q_word,
    output logic                          pop,
    output logic                          result_valid,
    output logic [wfc_pkg::IDX_W-1:0]     entry_index,
    output logic [wfc_pkg::TALLY_W-1:0]   word_count,
    output logic                          new_entry,
    output logic [wfc_pkg::STATUS_W-1:0]  status
);
    import wfc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [USED_W-1:0]   used_reg, used_next, e_reg, e_next;
    word_t               cur_reg;
    logic                rv_reg, rv_next, new_reg, new_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [TALLY_W-1:0]  cnt_reg, cnt_next, tally_inc;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic                row_we, tally_we, rd_en;
    logic [IDX_W-1:0]    waddr;
    logic [TALLY_W-1:0]  tally_wdata;
    logic [ROW_W-1:0]    row_rdata;
    logic [TALLY_W-1:0]  tally_rdata;
    logic                hit, too_short;

    assign hit       = (row_rdata == {cur_reg.len, cur_reg.chars});
    assign tally_inc = (tally_rdata == TALLY_MAX) ? tally_rdata : tally_rdata + TALLY_W'(1);
    assign too_short = (q_word.len == '0) || (LEN_W'(min_len) > q_word.len
                       && min_len > CFG_W'(MAX_WORD_BYTES) ? 1'b1 :
                       (q_word.len < LEN_W'(min_len)));

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        e_next      = e_reg;
        rv_next     = 1'b0;
        new_next    = 1'b0;
        idx_next    = '0;
        cnt_next    = '0;
        st_next     = ST_COUNTED;
        pop         = 1'b0;
        row_we      = 1'b0;
        tally_we    = 1'b0;
        rd_en       = 1'b0;
        waddr       = used_reg[IDX_W-1:0];
        tally_wdata = TALLY_W'(1);
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    if (q_word.over)
                    begin
                        rv_next = 1'b1;
                        st_next = ST_LONG;
                    end
                    else if (!too_short)
                    begin
                        e_next     = '0;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                if (e_reg == used_reg)
                begin
                    rv_next    = 1'b1;
                    state_next = S_IDLE;
                    if (used_reg == USED_W'(TABLE_ENTRIES))
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        row_we    = 1'b1;
                        tally_we  = 1'b1;
                        used_next = used_reg + USED_W'(1);
                        idx_next  = used_reg[IDX_W-1:0];
                        cnt_next  = TALLY_W'(1);
                        new_next  = 1'b1;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (hit)
                begin
                    waddr       = e_reg[IDX_W-1:0];
                    tally_we    = 1'b1;
                    tally_wdata = tally_inc;
                    rv_next     = 1'b1;
                    idx_next    = e_reg[IDX_W-1:0];
                    cnt_next    = tally_inc;
                    state_next  = S_IDLE;
                end
                else
                begin
                    e_next     = e_reg + USED_W'(1);
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            e_reg     <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            e_reg     <= e_next;
            rv_reg    <= rv_next;
        end
    end

    // current word and result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_word;
        end
        idx_reg <= idx_next;
        cnt_reg <= cnt_next;
        new_reg <= new_next;
        st_reg  <= st_next;
    end

    // stored words with their lengths
    wfc_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_ENTRIES)) u_rows (
        .clk   (clk),
        .we    (row_we),
        .waddr (waddr),
        .wdata ({cur_reg.len, cur_reg.chars}),
        .re    (rd_en),
        .raddr (e_reg[IDX_W-1:0]),
        .rdata (row_rdata)
    );

    // tallies
    wfc_ram #(.WIDTH(TALLY_W), .DEPTH(TABLE_ENTRIES)) u_tally (
        .clk   (clk),
        .we    (tally_we),
        .waddr (waddr),
        .wdata (tally_wdata),
        .re    (rd_en),
        .raddr (e_reg[IDX_W-1:0]),
        .rdata (tally_rdata)
    );

    assign result_valid = rv_reg;
    assign entry_index  = idx_reg;
    assign word_count   = cnt_reg;
    assign new_entry    = new_reg;
    assign status       = st_reg;

endmodule

// ----- sv/word_frequency_counter.sv -----
// top level of the word frequency counter
//
//  channel  | handshake                 | word
//  ---------+---------------------------+----------------------------------------
//  input    | start, busy               | text_byte, end_of_text
//  config   | cfg_valid, cfg_ready      | min_length
//  result   | result_valid (one cycle)  | entry_index, word_count, new_entry, status
//
// a byte is taken when start is high and busy is low; busy is high whenever the
// two-word queue is full. each queued word is popped; a word that is counted then
// has the used table entries scanned in turn (registered ram read, then compare)
// until a hit updates its tally, else it is inserted or reported with full status.
// reset clears the word state, queue, entry count and min_length (to 3).
// results cannot be held off by the receiver.
module word_frequency_counter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [7:0]                    text_byte,
    input  logic                          end_of_text,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wfc_pkg::CFG_W-1:0]     min_length,
    output logic                          result_valid,
    output logic [wfc_pkg::IDX_W-1:0]     entry_index,
    output logic [wfc_pkg::TALLY_W-1:0]   word_count,
    output logic                          new_entry,
    output logic [wfc_pkg::STATUS_W-1:0]  status
);
    import wfc_pkg::*;

    logic [CFG_W-1:0] min_len_reg;
    logic             accept, push, pop, q_empty, q_full;
    word_t            push_word, pop_word;

    assign busy      = q_full;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= MIN_LEN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            min_len_reg <= min_length;
        end
    end

    wfc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .push        (push),
        .push_word   (push_word)
    );

    wfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .pop_word  (pop_word),
        .empty     (q_empty),
        .full      (q_full)
    );

    wfc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .min_len      (min_len_reg),
        .q_empty      (q_empty),
        .q_word       (pop_word),
        .pop          (pop),
        .result_valid (result_valid),
        .entry_index  (entry_index),
        .word_count   (word_count),
        .new_entry    (new_entry),
        .status       (status)
    );

    // dropped words carry no entry and no count
    a_dropped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != ST_COUNTED |-> entry_index == '0 && word_count == '0)
        else $error("dropped word with nonzero payload");

    // a counted word never reports a zero tally
    a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_COUNTED |-> word_count != '0)
        else $error("counted word with zero tally");

    // a fresh entry starts at one
    a_new_is_one: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && new_entry |-> word_count == TALLY_W'(1) && status == ST_COUNTED)
        else $error("new entry with wrong tally");

    // no push into a full queue
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("queue overrun");

endmodule

// ----- tb/word_frequency_counter_test.sv -----
// testbench for the word frequency counter: directed and random text against a built-in predictor
module word_frequency_counter_test;

    timeunit 1ns;
    timeprecision 1ps;

    import wfc_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]    idx;
        logic [TALLY_W-1:0]  tally;
        logic                fresh;
        logic [STATUS_W-1:0] st;
    } word_result_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [7:0]          text_byte;
    logic                end_of_text;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_W-1:0]    min_length;
    logic                result_valid;
    logic [IDX_W-1:0]    entry_index;
    logic [TALLY_W-1:0]  word_count;
    logic                new_entry;
    logic [STATUS_W-1:0] status;

    // predictor state
    logic [7:0]       known_chars [TABLE_ENTRIES][MAX_WORD_BYTES];
    int               known_len   [TABLE_ENTRIES];
    int               known_tally [TABLE_ENTRIES];
    int               known_used;
    logic [7:0]       pending_chars [MAX_WORD_BYTES];
    int               pending_len;
    bit               pending_over;
    int               shortest;

    word_result_t     expected_words [$];
    int               mismatches;
    int               bytes_sent;
    int               words_checked;
    int               unique_seq;
    bit               idle_en;

    word_frequency_counter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .text_byte    (text_byte),
        .end_of_text  (end_of_text),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .min_length   (min_length),
        .result_valid (result_valid),
        .entry_index  (entry_index),
        .word_count   (word_count),
        .new_entry    (new_entry),
        .status       (status)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // close out the pending word and queue what the block should report
    function automatic void close_word();
        int  minl;
        bit  same;
        word_result_t r;
        minl = (shortest == 0) ? 1 : shortest;
        r = '{idx: '0, tally: '0, fresh: 1'b0, st: ST_COUNTED};
        if (pending_over)
        begin
            r.st = ST_LONG;
            expected_words.push_back(r);
        end
        else if (pending_len >= minl)
        begin
            for (int e = 0; e < known_used; e++)
            begin
                same = (known_len[e] == pending_len);
                for (int k = 0; k < pending_len && same; k++)
                    if (known_chars[e][k] != pending_chars[k])
                        same = 0;
                if (same)
                begin
                    if (known_tally[e] < 65535)
                        known_tally[e]++;
                    r.idx = e[IDX_W-1:0];
                    r.tally = known_tally[e][TALLY_W-1:0];
                    expected_words.push_back(r);
                    pending_len = 0;
                    pending_over = 0;
                    return;
                end
            end
            if (known_used >= TABLE_ENTRIES)
                r.st = ST_FULL;
            else
            begin
                for (int k = 0; k < pending_len; k++)
                    known_chars[known_used][k] = pending_chars[k];
                known_len[known_used] = pending_len;
                known_tally[known_used] = 1;
                r.idx = known_used[IDX_W-1:0];
                r.tally = TALLY_W'(1);
                r.fresh = 1'b1;
                known_used++;
            end
            expected_words.push_back(r);
        end
        pending_len = 0;
        pending_over = 0;
    endfunction

    // one accepted byte through the predictor
    function automatic void predict_byte(logic [7:0] b, logic eot);
        logic [7:0] c;
        c = b;
        if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
        begin
            close_word();
            return;
        end
        if (!(c inside {8'h2E, 8'h21, 8'h3F, 8'h2D, 8'h2C, 8'h28, 8'h29, 8'h27}))
        begin
            if (c >= "A" && c <= "Z")
                c = c + 8'h20;
            if (pending_len < MAX_WORD_BYTES)
            begin
                pending_chars[pending_len] = c;
                pending_len++;
            end
            else
                pending_over = 1;
        end
        if (eot)
            close_word();
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // result checker, sampled mid-cycle
    always @(negedge clk)
    begin
        word_result_t w;
        if (rst_n && result_valid)
        begin
            if (expected_words.size() == 0)
                report_mismatch("result with no word pending");
            else
            begin
                w = expected_words.pop_front();
                words_checked++;
                if (entry_index !== w.idx)
                    report_mismatch($sformatf("entry_index %0d, want %0d", entry_index, w.idx));
                if (word_count !== w.tally)
                    report_mismatch($sformatf("word_count %0d, want %0d", word_count, w.tally));
                if (new_entry !== w.fresh)
                    report_mismatch($sformatf("new_entry %0b, want %0b", new_entry, w.fresh));
                if (status !== w.st)
                    report_mismatch($sformatf("status %0d, want %0d", status, w.st));
            end
        end
    end

    // send one byte; start stays high on return
    task automatic send_byte(logic [7:0] b, logic eot);
        bit taken;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        start <= 1'b1;
        text_byte <= b;
        end_of_text <= eot;
        taken = 0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        predict_byte(b, eot);
        bytes_sent++;
    endtask

    task automatic send_text(string s, bit eot_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eot_last && (i == s.len() - 1));
    endtask

    // stop sending and let every pending word come back
    task automatic drain();
        start <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (2 * TABLE_ENTRIES + 12) @(posedge clk);
    endtask

    task automatic write_min_length(logic [CFG_W-1:0] v);
        bit taken;
        drain();
        cfg_valid <= 1'b1;
        min_length <= v;
        taken = 0;
        while (!taken)
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        shortest = int'(v);
    endtask

    function automatic string random_word(int vocab);
        string s;
        string marks;
        int    n;
        int    k;
        marks = ",.!?-()'";
        s = $sformatf("w%0dx", $urandom_range(0, vocab - 1));
        n = s.len();
        for (int i = 0; i < n; i++)
            if ($urandom_range(0, 2) == 0 && s[i] >= "a" && s[i] <= "z")
                s[i] = s[i] - 8'h20;
        if ($urandom_range(0, 3) == 0)
        begin
            k = $urandom_range(0, 7);
            s = {s, marks.substr(k, k)};
        end
        if ($urandom_range(0, 7) == 0)
            s = {"(", s};
        return s;
    endfunction

    function automatic logic [7:0] random_space();
        logic [7:0] sp [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
        return sp[$urandom_range(0, 5)];
    endfunction

    // edge cases of the text format
    task automatic test_directed();
        send_text("Hello, World! ", 1'b0);
        send_text("hello\tWORLD", 1'b1);
        send_text("... ", 1'b0);
        send_text("it's ", 1'b0);
        send_text("ab ", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_text("abcdefghijklmnopqrstuvwxyzABCDEF ", 1'b0);
        send_text("abcdefghijklmnopqrstuvwxyzabcdefg ", 1'b0);
        send_text("a-b-c-d-e-f-g-h-i-j-k-l-m-n-o-p-q-r-s-t-u-v-w-x-y-z-0-1-2-3-4-5", 1'b1);
        send_text("(done)\v\f\r\n", 1'b0);
        send_text("hello ", 1'b1);
    endtask

    // register extremes
    task automatic test_min_length();
        write_min_length(CFG_W'(1));
        send_text("a I x a ", 1'b0);
        write_min_length(CFG_W'(0));
        send_text("b - ", 1'b0);
        send_byte("c", 1'b1);
        write_min_length(CFG_W'(32));
        send_text("abcdefghijklmnopqrstuvwxyzABCDE abcdefghijklmnopqrstuvwxyzabcdef ", 1'b0);
        write_min_length(CFG_W'(63));
        send_text("zzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzz zzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzz ", 1'b0);
        write_min_length(CFG_W'(2));
        send_text("ok ok hi ", 1'b0);
    endtask

    // vocabulary text with noise and pauses
    task automatic test_random_text(int n_bytes, int vocab);
        string s;
        int    target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
        begin
            if ($urandom_range(0, 30) == 0)
                idle_en = !idle_en;
            if ($urandom_range(0, 9) == 0)
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            else
            begin
                s = random_word(vocab);
                if ($urandom_range(0, 5) == 0)
                    send_text(s, 1'b1);
                else
                begin
                    send_text(s, 1'b0);
                    send_byte(random_space(), 1'b0);
                end
            end
        end
    endtask

    // fill the table, then new words are dropped and known ones still count
    task automatic test_table_full();
        while (known_used < TABLE_ENTRIES)
        begin
            send_text($sformatf("uq%0d ", unique_seq), 1'b0);
            unique_seq++;
        end
        repeat (4)
        begin
            send_text($sformatf("uq%0d ", unique_seq), 1'b0);
            unique_seq++;
        end
        send_text("hello world Hello ", 1'b0);
    endtask

    // limit
    initial
    begin
        #20ms;
        $display("timeout");
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        text_byte = '0;
        end_of_text = 1'b0;
        cfg_valid = 1'b0;
        min_length = MIN_LEN_RST;
        known_used = 0;
        pending_len = 0;
        pending_over = 0;
        shortest = 3;
        mismatches = 0;
        bytes_sent = 0;
        words_checked = 0;
        unique_seq = 0;
        idle_en = 1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_min_length();
        write_min_length(CFG_W'(3));
        test_random_text(150, 24);
        // sender holds until everything has come back
        drain();
        test_random_text(80, 80);
        test_table_full();
        write_min_length(CFG_W'(1));
        test_random_text(100, 120);
        idle_en = 0;
        test_random_text(60, 40);
        drain();

        $display("sent %0d bytes, checked %0d words, %0d table entries used",
                 bytes_sent, words_checked, known_used);
        $display("covered case folding, dropped chars, long words, full table, min_length 0..63");
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- word_frequency_counter.f -----
sv/wfc_pkg.sv
sv/wfc_ram.sv
sv/wfc_front.sv
sv/wfc_queue.sv
sv/wfc_back.sv
sv/word_frequency_counter.sv
tb/word_frequency_counter_test.sv
